FILE: hdl/lpfd_pkg.sv
`default_nettype none

package lpfd_pkg;

    localparam int unsigned HEADER_BYTES = 11;
    localparam int unsigned CNT_W        = 4;

    // first header byte of each field, counted from the magic byte
    localparam logic [CNT_W-1:0] TYPE_START = CNT_W'(1);
    localparam logic [CNT_W-1:0] ADDR_START = CNT_W'(3);
    localparam logic [CNT_W-1:0] LEN_START  = CNT_W'(7);
    localparam logic [CNT_W-1:0] HDR_END    = CNT_W'(HEADER_BYTES);

    localparam logic [31:0] MAX_LEN_RESET = 32'd65536;
    localparam int unsigned ADDR_W        = 4;

    typedef enum logic [1:0] {
        REG_MAGIC  = 2'd0,
        REG_TAIL   = 2'd1,
        REG_MAXLEN = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        REC_PAYLOAD   = 3'd0,
        REC_FRAME_OK  = 3'd1,
        REC_BAD_MAGIC = 3'd2,
        REC_BAD_TAIL  = 3'd3,
        REC_OVERSIZE  = 3'd4
    } t_rec_kind;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_TAIL    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0]  magic;
        logic [7:0]  tail;
        logic [31:0] max_len;
    } t_cfg;

    typedef struct packed {
        t_rec_kind   kind;
        logic [7:0]  data;
        logic [15:0] mtype;
        logic [31:0] addr;
        logic [31:0] len;
        logic        last;
    } t_rec;

endpackage

`default_nettype wire

FILE: hdl/lpfd_regs.sv
`default_nettype none

module lpfd_regs
    import lpfd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]       i_pwdata,
    output logic [31:0]            o_prdata,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx = t_reg_idx'(i_paddr[ADDR_W-1:2]);
    assign w_wr  = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic   <= 8'd0;
            r_cfg.tail    <= 8'd0;
            r_cfg.max_len <= MAX_LEN_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MAGIC:  r_cfg.magic   <= i_pwdata[7:0];
                REG_TAIL:   r_cfg.tail    <= i_pwdata[7:0];
                REG_MAXLEN: r_cfg.max_len <= i_pwdata;
                default: ;  // unmapped, drop
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MAGIC:  o_prdata = {24'd0, r_cfg.magic};
            REG_TAIL:   o_prdata = {24'd0, r_cfg.tail};
            REG_MAXLEN: o_prdata = r_cfg.max_len;
            default:    o_prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hdl/length_prefixed_frame_deframer.sv
`default_nettype none
// A result item is registered into the output register, or the skid entry on a stall.
// Throughput: one byte per cycle while the skid entry is free; header bytes give no
// result item unless the length is oversize. The output register plus one skid entry
// absorb a stall downstream; input ready drops only while the skid entry is occupied.
// Reset (synchronous, active low): hunt for magic, header state cleared, registers
// back to reset values, output empty.

module length_prefixed_frame_deframer
    import lpfd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // byte stream in
    input  wire logic              i_rx_valid,
    output logic                   o_rx_ready,
    input  wire logic [7:0]        i_rx_byte,
    // record stream out
    output logic                   o_rec_valid,
    input  wire logic              i_rec_ready,
    output logic [2:0]             o_record_kind,
    output logic [7:0]             o_payload_byte,
    output logic [15:0]            o_message_type,
    output logic [31:0]            o_source_address,
    output logic [31:0]            o_payload_length,
    output logic                   o_frame_last
);

    t_cfg w_cfg;

    lpfd_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    assign pready = 1'b1;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0]      r_type, n_type;
    logic [31:0]      r_addr, n_addr;
    logic [31:0]      r_len, n_len;
    logic [31:0]      r_rem, n_rem;

    t_rec r_out, r_skid, w_rec;
    logic r_out_valid, r_skid_valid;
    logic w_rec_hit, w_rx_acc, w_out_take;

    logic [CNT_W-1:0] w_cnt_inc;
    logic [31:0]      w_rem_dec;

    assign o_rx_ready = !r_skid_valid;
    assign w_rx_acc   = i_rx_valid & o_rx_ready;
    assign w_out_take = r_out_valid & i_rec_ready;
    assign w_cnt_inc  = r_cnt + CNT_W'(1);
    assign w_rem_dec  = (r_rem != 32'd0) ? r_rem - 32'd1 : 32'd0;

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_type    = r_type;
        n_addr    = r_addr;
        n_len     = r_len;
        n_rem     = r_rem;
        w_rec_hit = 1'b0;
        w_rec     = '0;
        if (w_rx_acc) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == w_cfg.magic) begin
                        n_phase = PH_HEADER;
                        n_cnt   = CNT_W'(1);
                        n_type  = 16'd0;
                        n_addr  = 32'd0;
                        n_len   = 32'd0;
                    end else begin
                        w_rec_hit  = 1'b1;
                        w_rec.kind = REC_BAD_MAGIC;
                        w_rec.last = 1'b1;
                    end
                end
                PH_HEADER: begin
                    if (r_cnt < ADDR_START) begin
                        n_type = {r_type[7:0], i_rx_byte};
                    end else if (r_cnt < LEN_START) begin
                        n_addr = {r_addr[23:0], i_rx_byte};
                    end else begin
                        n_len = {r_len[23:0], i_rx_byte};
                    end
                    n_cnt = w_cnt_inc;
                    if (w_cnt_inc == HDR_END) begin
                        n_cnt = '0;
                        if (n_len > w_cfg.max_len) begin
                            n_phase    = PH_HUNT;
                            w_rec_hit  = 1'b1;
                            w_rec.kind = REC_OVERSIZE;
                            w_rec.last = 1'b1;
                        end else begin
                            n_rem   = n_len;
                            n_phase = (n_len == 32'd0) ? PH_TAIL : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    w_rec_hit  = 1'b1;
                    w_rec.kind = REC_PAYLOAD;
                    w_rec.data = i_rx_byte;
                    n_rem      = w_rem_dec;
                    if (w_rem_dec == 32'd0) begin
                        n_phase = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    n_phase    = PH_HUNT;
                    w_rec_hit  = 1'b1;
                    w_rec.kind = (i_rx_byte == w_cfg.tail) ? REC_FRAME_OK : REC_BAD_TAIL;
                    w_rec.last = 1'b1;
                end
                default: n_phase = PH_HUNT;
            endcase
            // every record but bad magic carries the header as it now stands
            if (w_rec.kind != REC_BAD_MAGIC) begin
                w_rec.mtype = n_type;
                w_rec.addr  = n_addr;
                w_rec.len   = n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cnt   <= '0;
            r_type  <= 16'd0;
            r_addr  <= 32'd0;
            r_len   <= 32'd0;
            r_rem   <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_type  <= n_type;
            r_addr  <= n_addr;
            r_len   <= n_len;
            r_rem   <= n_rem;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_rec_hit) begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_take) begin
                r_out <= r_skid;
            end
        end else if (w_rec_hit) begin
            if (!r_out_valid || w_out_take) begin
                r_out <= w_rec;
            end else begin
                r_skid <= w_rec;
            end
        end
    end

    assign o_rec_valid      = r_out_valid;
    assign o_record_kind    = r_out.kind;
    assign o_payload_byte   = r_out.data;
    assign o_message_type   = r_out.mtype;
    assign o_source_address = r_out.addr;
    assign o_payload_length = r_out.len;
    assign o_frame_last     = r_out.last;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_last_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid |-> (o_frame_last == (o_record_kind != REC_PAYLOAD)))
        else $error("frame_last disagrees with record kind");

    a_hunt_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HUNT) |-> (r_cnt == '0))
        else $error("header count not cleared while hunting");

    a_bad_magic_no_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rec_valid && o_record_kind == REC_BAD_MAGIC) |->
            (o_source_address == 32'd0 && o_payload_length == 32'd0))
        else $error("bad magic record carries header fields");

endmodule

`default_nettype wire
